FILE: src/assert_macros.svh
// Assertion macros used by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/uidd_pkg.sv
// Shared constants, types and helpers of the UID packet deframer.
`default_nettype none
package uidd_pkg;

    localparam int CHANNELS    = 2;
    localparam int MAX_UID_LEN = 10;
    localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ID_DEPTH    = CHANNELS * MAX_UID_LEN;
    localparam int ID_AW       = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READER_LIMIT = 1'd1;

    localparam logic [7:0] START_RESET = 8'd170;
    localparam logic [1:0] LIMIT_RESET = 2'd2;

    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_READER = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_UID    = 3'd3;
    localparam logic [2:0] PH_SUM    = 3'd4;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] reader;
        logic [3:0] length;
        logic [3:0] seen;
        logic [7:0] xsum;
    } t_ctx;

    typedef struct packed {
        logic             en;
        logic [CH_AW-1:0] addr;
        t_ctx             data;
    } t_ctx_wr;

    function automatic logic [ID_AW-1:0] id_addr(input logic [CH_AW-1:0] ch,
                                                 input logic [3:0] pos);
        int sum;
        sum = int'(ch) * MAX_UID_LEN + int'(pos);
        return sum[ID_AW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/uidd_ctx_ram.sv
// Per-channel deframer context memory with valid bits, unwritten entries read as reset.
`default_nettype none
module uidd_ctx_ram (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_rd_en,
    input  wire  [uidd_pkg::CH_AW-1:0]     i_rd_addr,
    output uidd_pkg::t_ctx                 o_rd_data,
    input  uidd_pkg::t_ctx_wr              i_wr
);

    uidd_pkg::t_ctx                  r_mem [uidd_pkg::CHANNELS];
    logic [uidd_pkg::CHANNELS-1:0]   r_vld;
    uidd_pkg::t_ctx                  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: src/uidd_id_ram.sv
// UID byte store, one row of bytes per channel, registered read.
`default_nettype none
module uidd_id_ram (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [uidd_pkg::ID_AW-1:0]   i_wr_addr,
    input  wire  [7:0]                   i_wr_data,
    input  wire                          i_rd_en,
    input  wire  [uidd_pkg::ID_AW-1:0]   i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    logic [7:0] r_mem [uidd_pkg::ID_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: src/uid_packet_deframer_unit.sv
// Top level of the UID packet deframer: sequencer, config registers, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_channel, i_rx_byte
//  out     | output    | o_out_valid / i_out_ready  | src_channel .. last
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A byte passes a context read, then a modify and write back.
// After a good checksum each UID byte takes a store read, then a result load that waits
// for a free result register; an error result also waits for a free result register.
// Reset is synchronous; context valid bits clear at once, no clearing pass.
// The result register holds an item under stall while the next byte is accepted.
`default_nettype none
`include "assert_macros.svh"
module uid_packet_deframer_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_channel,
    input  wire  [7:0]                       i_rx_byte,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_src_channel,
    output logic                             o_status,
    output logic [1:0]                       o_reader_id,
    output logic [3:0]                       o_id_length,
    output logic [3:0]                       o_byte_position,
    output logic [7:0]                       o_id_byte,
    output logic                             o_last,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [uidd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [7:0]                       i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CTX  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_start, n_start;
    logic [1:0]   r_limit, n_limit;
    logic         r_ch, n_ch;
    logic [7:0]   r_byte, n_byte;
    logic [3:0]   r_pos, n_pos;
    logic [3:0]   r_len, n_len;
    logic [1:0]   r_rdr, n_rdr;

    logic         r_out_valid, n_out_valid;
    logic         r_out_ch, n_out_ch;
    logic         r_out_status, n_out_status;
    logic [1:0]   r_out_rdr, n_out_rdr;
    logic [3:0]   r_out_len, n_out_len;
    logic [3:0]   r_out_pos, n_out_pos;
    logic [7:0]   r_out_byte, n_out_byte;
    logic         r_out_last, n_out_last;

    logic                          accept;
    logic                          ch_ok;
    logic                          ctx_rd_en;
    uidd_pkg::t_ctx                ctx_rd;
    uidd_pkg::t_ctx                ctx_nx;
    uidd_pkg::t_ctx_wr             ctx_wr;
    logic                          id_wr_en;
    logic                          id_rd_en;
    logic [7:0]                    id_rd_data;
    logic                          out_free;
    logic                          sum_hit;
    logic                          mismatch;
    logic                          stall;
    logic [3:0]                    seen_inc;
    logic [3:0]                    pos_inc;
    logic                          burst_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign ch_ok       = (int'(i_channel) < uidd_pkg::CHANNELS);
    assign ctx_rd_en   = accept && ch_ok;
    assign out_free    = !r_out_valid || i_out_ready;

    assign sum_hit    = (ctx_rd.phase == uidd_pkg::PH_SUM);
    assign mismatch   = (r_byte != ctx_rd.xsum);
    assign stall      = (r_state == ST_CTX) && sum_hit && mismatch && !out_free;
    assign seen_inc   = ctx_rd.seen + 4'd1;
    assign pos_inc    = r_pos + 4'd1;
    assign burst_last = (pos_inc == r_len);

    assign id_wr_en = (r_state == ST_CTX) && (ctx_rd.phase == uidd_pkg::PH_UID)
                      && (ctx_rd.seen < 4'(uidd_pkg::MAX_UID_LEN));
    assign id_rd_en = (r_state == ST_RD);

    always_comb begin
        ctx_nx = ctx_rd;
        case (ctx_rd.phase)
            uidd_pkg::PH_READER: begin
                if (r_byte > {6'd0, r_limit}) begin
                    ctx_nx.phase = uidd_pkg::PH_WAIT;
                end else begin
                    ctx_nx.reader = r_byte[1:0];
                    ctx_nx.xsum   = ctx_rd.xsum ^ r_byte;
                    ctx_nx.phase  = uidd_pkg::PH_LEN;
                end
            end
            uidd_pkg::PH_LEN: begin
                if (r_byte == 8'd0 || r_byte > 8'(uidd_pkg::MAX_UID_LEN)) begin
                    ctx_nx.phase = uidd_pkg::PH_WAIT;
                end else begin
                    ctx_nx.length = r_byte[3:0];
                    ctx_nx.seen   = 4'd0;
                    ctx_nx.xsum   = ctx_rd.xsum ^ r_byte;
                    ctx_nx.phase  = uidd_pkg::PH_UID;
                end
            end
            uidd_pkg::PH_UID: begin
                ctx_nx.seen = seen_inc;
                ctx_nx.xsum = ctx_rd.xsum ^ r_byte;
                if (seen_inc == ctx_rd.length) begin
                    ctx_nx.phase = uidd_pkg::PH_SUM;
                end
            end
            uidd_pkg::PH_SUM: begin
                ctx_nx.phase = uidd_pkg::PH_WAIT;
            end
            default: begin
                ctx_nx.phase = uidd_pkg::PH_WAIT;
                if (r_byte == r_start) begin
                    ctx_nx.xsum  = r_start;
                    ctx_nx.phase = uidd_pkg::PH_READER;
                end
            end
        endcase
    end

    assign ctx_wr.en   = (r_state == ST_CTX) && !stall;
    assign ctx_wr.addr = uidd_pkg::CH_AW'(r_ch);
    assign ctx_wr.data = ctx_nx;

    uidd_ctx_ram u_ctx_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ctx_rd_en),
        .i_rd_addr (uidd_pkg::CH_AW'(i_channel)),
        .o_rd_data (ctx_rd),
        .i_wr      (ctx_wr)
    );

    uidd_id_ram u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (id_wr_en),
        .i_wr_addr (uidd_pkg::id_addr(uidd_pkg::CH_AW'(r_ch), ctx_rd.seen)),
        .i_wr_data (r_byte),
        .i_rd_en   (id_rd_en),
        .i_rd_addr (uidd_pkg::id_addr(uidd_pkg::CH_AW'(r_ch), r_pos)),
        .o_rd_data (id_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_limit      = r_limit;
        n_ch         = r_ch;
        n_byte       = r_byte;
        n_pos        = r_pos;
        n_len        = r_len;
        n_rdr        = r_rdr;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_ch     = r_out_ch;
        n_out_status = r_out_status;
        n_out_rdr    = r_out_rdr;
        n_out_len    = r_out_len;
        n_out_pos    = r_out_pos;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                uidd_pkg::CFG_START_BYTE:   n_start = i_cfg_data;
                uidd_pkg::CFG_READER_LIMIT: n_limit = i_cfg_data[1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (ctx_rd_en) begin
                    n_ch    = i_channel;
                    n_byte  = i_rx_byte;
                    n_state = ST_CTX;
                end
            end
            ST_CTX: begin
                if (!stall) begin
                    n_state = ST_IDLE;
                    if (sum_hit && mismatch) begin
                        n_out_valid  = 1'b1;
                        n_out_ch     = r_ch;
                        n_out_status = 1'b1;
                        n_out_rdr    = ctx_rd.reader;
                        n_out_len    = ctx_rd.length;
                        n_out_pos    = 4'd0;
                        n_out_byte   = 8'd0;
                        n_out_last   = 1'b1;
                    end else if (sum_hit) begin
                        n_pos   = 4'd0;
                        n_len   = ctx_rd.length;
                        n_rdr   = ctx_rd.reader;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ch     = r_ch;
                    n_out_status = 1'b0;
                    n_out_rdr    = r_rdr;
                    n_out_len    = r_len;
                    n_out_pos    = r_pos;
                    n_out_byte   = id_rd_data;
                    n_out_last   = burst_last;
                    n_pos        = pos_inc;
                    n_state      = burst_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= uidd_pkg::START_RESET;
            r_limit     <= uidd_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_byte       <= n_byte;
        r_pos        <= n_pos;
        r_len        <= n_len;
        r_rdr        <= n_rdr;
        r_out_ch     <= n_out_ch;
        r_out_status <= n_out_status;
        r_out_rdr    <= n_out_rdr;
        r_out_len    <= n_out_len;
        r_out_pos    <= n_out_pos;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_src_channel   = r_out_ch;
    assign o_status        = r_out_status;
    assign o_reader_id     = r_out_rdr;
    assign o_id_length     = r_out_len;
    assign o_byte_position = r_out_pos;
    assign o_id_byte       = r_out_byte;
    assign o_last          = r_out_last;

    `ASSERT_NOW(a_sum_len_legal, (r_state == ST_CTX) && sum_hit, (ctx_rd.length != 4'd0) && (ctx_rd.length <= 4'(uidd_pkg::MAX_UID_LEN)), "checksum phase with illegal length")
    `ASSERT_NOW(a_burst_in_range, (r_state == ST_RD) || (r_state == ST_LOAD), r_pos < r_len, "burst position beyond length")
    `ASSERT_NOW(a_err_shape, r_out_valid && r_out_status, r_out_last && (r_out_byte == 8'd0) && (r_out_pos == 4'd0), "malformed error item")
    `ASSERT_NEXT(a_last_ends_burst, (r_state == ST_LOAD) && out_free && burst_last, r_state == ST_IDLE, "burst did not end on last item")

endmodule
`default_nettype wire
